// File: src/timed_event_min_heap_macros.svh
// assertion macros for the timed event min-heap
// expects clk_i and rst_ni in the scope of use
`ifndef TIMED_EVENT_MIN_HEAP_MACROS_SVH
`define TIMED_EVENT_MIN_HEAP_MACROS_SVH

// plain property checked on every clock edge out of reset
`define TEMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define TEMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/temh_pkg.sv
// types and codes shared by the timed event min-heap modules
// no dependencies
package temh_pkg;

  localparam int TIME_W        = 64;
  localparam int STATUS_W      = 2;
  localparam int EVENT_COUNT_W = 7;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_PUSH_INIT,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_UP_PLACE,
    OP_POP_INIT,
    OP_POP_LAST,
    OP_DN_RDL,
    OP_DN_RDR,
    OP_DN_MOVE,
    OP_DN_PLACE,
    OP_UPD_RD,
    OP_UPD_WR,
    OP_HEAD_RD,
    OP_HEAD_CAP
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_LAST,
    S_DN_CHK,
    S_DN_RDR,
    S_DN_CMP,
    S_UPD_WR,
    S_HEAD_RD,
    S_HEAD_CAP
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e    cmd;
    status_e status;
    logic    up_root;
    logic    up_move;
    logic    dn_leaf;
    logic    dn_move;
  } dp_stat_t;

endpackage

// File: src/timed_event_min_heap.sv
// timed event min-heap: one word in, one result word out per command
// push sifts the new word up from the last slot, pop moves the last word into the root
// and sifts it down, update rewrites the head word; a rejected, ignored or no-op command
// goes straight to the head read; the idle state takes the next word, also while a result
// waits; async active-low reset empties the heap and clears the id counter and tracked
// mark; depends on temh_pkg, temh_ctrl, temh_dp
module timed_event_min_heap import temh_pkg::*; #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_WIDTH = 16,
  parameter int LENGTH_WIDTH = 16,
  parameter int ID_WIDTH     = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [TIME_W-1:0]        due_time_i,
  input  logic [HANDLE_WIDTH-1:0]  msg_handle_i,
  input  logic [LENGTH_WIDTH-1:0]  msg_length_i,
  input  logic                     is_put_response_i,
  input  logic [LENGTH_WIDTH-1:0]  advance_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     empty_res_o,
  output logic [TIME_W-1:0]        head_time_o,
  output logic [ID_WIDTH-1:0]      head_id_o,
  output logic [HANDLE_WIDTH-1:0]  head_handle_o,
  output logic [LENGTH_WIDTH-1:0]  head_offset_o,
  output logic [LENGTH_WIDTH-1:0]  head_remaining_o,
  output logic                     last_put_sent_o,
  output logic [EVENT_COUNT_W-1:0] event_count_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  temh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  temh_dp #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .ID_WIDTH     (ID_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .dp_stat_o         (dp_stat),
    .cmd_i             (cmd_i),
    .due_time_i        (due_time_i),
    .msg_handle_i      (msg_handle_i),
    .msg_length_i      (msg_length_i),
    .is_put_response_i (is_put_response_i),
    .advance_i         (advance_i),
    .status_o          (status_o),
    .empty_res_o       (empty_res_o),
    .head_time_o       (head_time_o),
    .head_id_o         (head_id_o),
    .head_handle_o     (head_handle_o),
    .head_offset_o     (head_offset_o),
    .head_remaining_o  (head_remaining_o),
    .last_put_sent_o   (last_put_sent_o),
    .event_count_o     (event_count_o)
  );

endmodule

// File: src/temh_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module temh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/temh_dp.sv
// heap datapath: slot ram, sift registers, tracked position, result registers
// depends on temh_pkg, temh_ram and the assertion macro header
`include "timed_event_min_heap_macros.svh"

module temh_dp import temh_pkg::*; #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_WIDTH = 16,
  parameter int LENGTH_WIDTH = 16,
  parameter int ID_WIDTH     = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  dp_cmd_i,
  output dp_stat_t                 dp_stat_o,
  input  logic [1:0]               cmd_i,
  input  logic [TIME_W-1:0]        due_time_i,
  input  logic [HANDLE_WIDTH-1:0]  msg_handle_i,
  input  logic [LENGTH_WIDTH-1:0]  msg_length_i,
  input  logic                     is_put_response_i,
  input  logic [LENGTH_WIDTH-1:0]  advance_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     empty_res_o,
  output logic [TIME_W-1:0]        head_time_o,
  output logic [ID_WIDTH-1:0]      head_id_o,
  output logic [HANDLE_WIDTH-1:0]  head_handle_o,
  output logic [LENGTH_WIDTH-1:0]  head_offset_o,
  output logic [LENGTH_WIDTH-1:0]  head_remaining_o,
  output logic                     last_put_sent_o,
  output logic [EVENT_COUNT_W-1:0] event_count_o
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int PW    = AW + 1;
  localparam int RM_LO = 0;
  localparam int OF_LO = LENGTH_WIDTH;
  localparam int HD_LO = 2 * LENGTH_WIDTH;
  localparam int ID_LO = HD_LO + HANDLE_WIDTH;
  localparam int TM_LO = ID_LO + ID_WIDTH;
  localparam int EW    = TM_LO + TIME_W;
  localparam logic [PW-1:0] TRK_NONE = '1;
  localparam logic [PW-1:0] CAP_P    = PW'(CAPACITY);
  localparam logic [LENGTH_WIDTH-1:0] LMAX = '1;

  function automatic logic before_f(input logic [EW-1:0] a, input logic [EW-1:0] b);
    if (a[TM_LO +: TIME_W] != b[TM_LO +: TIME_W]) begin
      before_f = a[TM_LO +: TIME_W] < b[TM_LO +: TIME_W];
    end else begin
      before_f = a[ID_LO +: ID_WIDTH] < b[ID_LO +: ID_WIDTH];
    end
  endfunction

  cmd_e                    cmd_q;
  status_e                 status_q;
  logic [TIME_W-1:0]       time_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  logic [LENGTH_WIDTH-1:0] len_q;
  logic                    put_q;
  logic [LENGTH_WIDTH-1:0] adv_q;
  logic [EW-1:0]           x_q;
  logic [EW-1:0]           l_q;
  logic                    r_ok_q;
  logic [PW-1:0]           idx_q;
  logic [PW-1:0]           count_q;
  logic [PW-1:0]           trk_q;
  logic [ID_WIDTH-1:0]     id_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_rd_en;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [PW-1:0] parent;
  logic [PW:0]   left;
  logic [PW:0]   right;
  logic [PW:0]   count_ext;
  logic [PW-1:0] last_pos;
  logic          up_move;
  logic          best_is_l;
  logic          best_is_r;
  logic [EW-1:0] best_lx;
  logic [EW-1:0] best_entry;
  logic [PW:0]   best_idx;
  logic [EW-1:0] upd_entry;
  logic [LENGTH_WIDTH-1:0] off_cur;
  logic [LENGTH_WIDTH-1:0] rem_cur;
  logic [LENGTH_WIDTH-1:0] off_new;
  logic [LENGTH_WIDTH-1:0] rem_new;
  status_e       status_new;

  temh_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .rd_en_i (ram_rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // index arithmetic and compares
  always_comb begin
    parent    = (idx_q - 1'b1) >> 1;
    left      = {idx_q, 1'b1};
    right     = left + 1'b1;
    count_ext = {1'b0, count_q};
    last_pos  = count_q - 1'b1;
    up_move   = before_f(x_q, ram_rdata);
    best_is_l = before_f(l_q, x_q);
    best_lx   = best_is_l ? l_q : x_q;
    best_is_r = r_ok_q && before_f(ram_rdata, best_lx);
    best_entry = best_is_r ? ram_rdata : l_q;
    best_idx   = best_is_r ? right : left;
  end

  // saturating progress update of the head word
  always_comb begin
    off_cur = ram_rdata[OF_LO +: LENGTH_WIDTH];
    rem_cur = ram_rdata[RM_LO +: LENGTH_WIDTH];
    off_new = (off_cur > (LMAX - adv_q)) ? LMAX : (off_cur + adv_q);
    rem_new = (rem_cur > adv_q) ? (rem_cur - adv_q) : '0;
    upd_entry = ram_rdata;
    upd_entry[OF_LO +: LENGTH_WIDTH] = off_new;
    upd_entry[RM_LO +: LENGTH_WIDTH] = rem_new;
  end

  always_comb begin
    case (cmd_e'(cmd_i))
      CMD_PUSH:   status_new = (count_q >= CAP_P) ? ST_FULL : ST_DONE;
      CMD_POP:    status_new = (count_q == '0) ? ST_EMPTY : ST_DONE;
      CMD_UPDATE: status_new = (count_q == '0) ? ST_EMPTY : ST_DONE;
      default:    status_new = ST_DONE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = x_q;
    ram_rd_en = 1'b0;
    ram_raddr = '0;
    case (dp_cmd_i.op)
      OP_UP_RD: begin
        ram_rd_en = 1'b1;
        ram_raddr = parent[AW-1:0];
      end
      OP_UP_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      OP_UP_PLACE, OP_DN_PLACE: begin
        ram_we = 1'b1;
      end
      OP_POP_INIT: begin
        ram_rd_en = 1'b1;
        ram_raddr = last_pos[AW-1:0];
      end
      OP_DN_RDL: begin
        ram_rd_en = 1'b1;
        ram_raddr = left[AW-1:0];
      end
      OP_DN_RDR: begin
        ram_rd_en = r_ok_q;
        ram_raddr = right[AW-1:0];
      end
      OP_DN_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = best_entry;
      end
      OP_UPD_RD, OP_HEAD_RD: begin
        ram_rd_en = 1'b1;
      end
      OP_UPD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = upd_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      trk_q   <= TRK_NONE;
      id_q    <= '0;
      idx_q   <= '0;
      r_ok_q  <= 1'b0;
      cmd_q   <= CMD_NOP;
      status_q <= ST_DONE;
    end else begin
      case (dp_cmd_i.op)
        OP_LOAD: begin
          cmd_q    <= cmd_e'(cmd_i);
          status_q <= status_new;
        end
        OP_PUSH_INIT: begin
          idx_q   <= count_q;
          count_q <= count_q + 1'b1;
          id_q    <= id_q + 1'b1;
        end
        OP_UP_MOVE: begin
          if (trk_q == parent) begin
            trk_q <= idx_q;
          end
          idx_q <= parent;
        end
        OP_UP_PLACE: begin
          if (put_q) begin
            trk_q <= idx_q;
          end
        end
        OP_POP_INIT: begin
          if (trk_q == '0) begin
            trk_q <= TRK_NONE;
          end
        end
        OP_POP_LAST: begin
          // last word moves into the root hole
          count_q <= last_pos;
          idx_q   <= '0;
          if (trk_q == last_pos) begin
            trk_q <= '0;
          end
        end
        OP_DN_RDL: begin
          r_ok_q <= right < count_ext;
        end
        OP_DN_MOVE: begin
          if (trk_q == idx_q) begin
            trk_q <= best_idx[PW-1:0];
          end else if ({1'b0, trk_q} == best_idx) begin
            trk_q <= idx_q;
          end
          idx_q <= best_idx[PW-1:0];
        end
        default: begin
          r_ok_q <= r_ok_q;
        end
      endcase
    end
  end

  // payload, sift and result registers
  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      OP_LOAD: begin
        time_q   <= due_time_i;
        handle_q <= msg_handle_i;
        len_q    <= msg_length_i;
        put_q    <= is_put_response_i;
        adv_q    <= advance_i;
      end
      OP_PUSH_INIT: begin
        x_q <= {time_q, id_q, handle_q, {LENGTH_WIDTH{1'b0}}, len_q};
      end
      OP_POP_LAST: begin
        x_q <= ram_rdata;
      end
      OP_DN_RDR: begin
        l_q <= ram_rdata;
      end
      OP_HEAD_CAP: begin
        status_o        <= status_q;
        empty_res_o     <= count_q == '0;
        last_put_sent_o <= trk_q == TRK_NONE;
        event_count_o   <= EVENT_COUNT_W'(count_q);
        if (count_q == '0) begin
          head_time_o      <= '0;
          head_id_o        <= '0;
          head_handle_o    <= '0;
          head_offset_o    <= '0;
          head_remaining_o <= '0;
        end else begin
          head_time_o      <= ram_rdata[TM_LO +: TIME_W];
          head_id_o        <= ram_rdata[ID_LO +: ID_WIDTH];
          head_handle_o    <= ram_rdata[HD_LO +: HANDLE_WIDTH];
          head_offset_o    <= ram_rdata[OF_LO +: LENGTH_WIDTH];
          head_remaining_o <= ram_rdata[RM_LO +: LENGTH_WIDTH];
        end
      end
      default: begin
        time_q <= time_q;
      end
    endcase
  end

  always_comb begin
    dp_stat_o.cmd     = cmd_q;
    dp_stat_o.status  = status_q;
    dp_stat_o.up_root = idx_q == '0;
    dp_stat_o.up_move = up_move;
    dp_stat_o.dn_leaf = left >= count_ext;
    dp_stat_o.dn_move = best_is_l || best_is_r;
  end

  `TEMH_ASSERT(a_count_bound, count_q <= CAP_P, "held count above capacity")
  `TEMH_ASSERT(a_trk_in_heap, (trk_q == TRK_NONE) || (trk_q < count_q), "tracked position outside heap")
  `TEMH_ASSERT_IMP(a_id_on_push, id_q != $past(id_q), count_q == $past(count_q) + 1'b1, "id used without push")

endmodule

// File: src/temh_ctrl.sv
// heap controller: sequences push sift-up, pop sift-down, update and head read
// depends on temh_pkg
module temh_ctrl import temh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  dp_cmd_o,
  input  dp_stat_t dp_stat_i
);

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (dp_stat_i.status != ST_DONE) begin
          state_d = S_HEAD_RD;
        end else begin
          case (dp_stat_i.cmd)
            CMD_PUSH:   state_d = S_UP_CHK;
            CMD_POP:    state_d = S_POP_LAST;
            CMD_UPDATE: state_d = S_UPD_WR;
            default:    state_d = S_HEAD_RD;
          endcase
        end
      end
      S_UP_CHK:   state_d = dp_stat_i.up_root ? S_HEAD_RD : S_UP_CMP;
      S_UP_CMP:   state_d = dp_stat_i.up_move ? S_UP_CHK : S_HEAD_RD;
      S_POP_LAST: state_d = S_DN_CHK;
      S_DN_CHK:   state_d = dp_stat_i.dn_leaf ? S_HEAD_RD : S_DN_RDR;
      S_DN_RDR:   state_d = S_DN_CMP;
      S_DN_CMP:   state_d = dp_stat_i.dn_move ? S_DN_CHK : S_HEAD_RD;
      S_UPD_WR:   state_d = S_HEAD_RD;
      S_HEAD_RD:  state_d = S_HEAD_CAP;
      S_HEAD_CAP: if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o.op = OP_IDLE;
    case (state_q)
      S_IDLE: if (in_valid_i) dp_cmd_o.op = OP_LOAD;
      S_DISPATCH: begin
        if (dp_stat_i.status == ST_DONE) begin
          case (dp_stat_i.cmd)
            CMD_PUSH:   dp_cmd_o.op = OP_PUSH_INIT;
            CMD_POP:    dp_cmd_o.op = OP_POP_INIT;
            CMD_UPDATE: dp_cmd_o.op = OP_UPD_RD;
            default:    dp_cmd_o.op = OP_IDLE;
          endcase
        end
      end
      S_UP_CHK:   dp_cmd_o.op = dp_stat_i.up_root ? OP_UP_PLACE : OP_UP_RD;
      S_UP_CMP:   dp_cmd_o.op = dp_stat_i.up_move ? OP_UP_MOVE : OP_UP_PLACE;
      S_POP_LAST: dp_cmd_o.op = OP_POP_LAST;
      S_DN_CHK:   dp_cmd_o.op = dp_stat_i.dn_leaf ? OP_DN_PLACE : OP_DN_RDL;
      S_DN_RDR:   dp_cmd_o.op = OP_DN_RDR;
      S_DN_CMP:   dp_cmd_o.op = dp_stat_i.dn_move ? OP_DN_MOVE : OP_DN_PLACE;
      S_UPD_WR:   dp_cmd_o.op = OP_UPD_WR;
      S_HEAD_RD:  dp_cmd_o.op = OP_HEAD_RD;
      S_HEAD_CAP: if (out_free) dp_cmd_o.op = OP_HEAD_CAP;
      default:    dp_cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_HEAD_CAP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
